// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions; clk and rst_n come from the using scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ICD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ICD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/icd_pkg.sv =====
// ---------------------------------------------------------------------------
// icd_pkg
// Sizes, types and operation codes of the indexed circular deque.
// ---------------------------------------------------------------------------
package icd_pkg;

    localparam int DEPTH    = 16;
    localparam int WIDTH    = 32;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int FUNC_W   = 4;
    localparam int INDEX_W  = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [WIDTH-1:0]   word_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [PTR_W:0]     wide_ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH     = 4'd0,
        OP_POP      = 4'd1,
        OP_ENQUEUE  = 4'd2,
        OP_DEQUEUE  = 4'd3,
        OP_PEEK     = 4'd4,
        OP_GET      = 4'd5,
        OP_SET      = 4'd6,
        OP_INSB     = 4'd7,
        OP_INSA     = 4'd8,
        OP_REMOVE   = 4'd9,
        OP_SWAPREM  = 4'd10,
        OP_CLEAR    = 4'd11
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SH_RD,
        S_SH_WR,
        S_FINAL
    } state_t;

endpackage

// ===== sv/indexed_circular_deque.sv =====
// ---------------------------------------------------------------------------
// indexed_circular_deque
// Fixed-capacity ring deque with end operations and indexed access, insert
// and remove. Entries live in one simple dual-port RAM.
// ---------------------------------------------------------------------------
//  channel | signals                      | transfer
//  --------+------------------------------+-------------------------------
//  command | func, index, value           | start high while busy low
//  result  | data_out, status, count      | done high for one cycle
//
//  End operations, peek, get, set, swap-remove and clear: accept, then one
//  RAM read-modify-write. Insert and remove: accept, execute, then N entries
//  move one slot, then a final state; each move is a RAM read then a write.
//  Reset empties the deque at once; RAM contents are left as they are.
//  The result side cannot stall; busy holds off new commands.
// ---------------------------------------------------------------------------
module indexed_circular_deque (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  func,
    input  logic [3:0]  index,
    input  logic [31:0] value,
    output logic        done,
    output logic [31:0] data_out,
    output logic [1:0]  status,
    output logic [4:0]  count
);

    icd_pkg::state_t  state_reg, state_next;
    logic [3:0]       op_reg, op_next;
    icd_pkg::index_t  idx_reg, idx_next;
    icd_pkg::word_t   val_reg, val_next;
    icd_pkg::ptr_t    front_reg, front_next;
    icd_pkg::cnt_t    occ_reg, occ_next;
    icd_pkg::cnt_t    sh_i_reg, sh_i_next;
    icd_pkg::cnt_t    pos_reg, pos_next;
    logic             up_reg, up_next;
    logic             done_reg, done_next;
    icd_pkg::data_t   data_out_reg, data_out_next;
    icd_pkg::status_t status_reg, status_next;
    icd_pkg::count_t  count_reg, count_next;

    logic             ram_we;
    icd_pkg::ptr_t    ram_waddr;
    icd_pkg::word_t   ram_wdata;
    icd_pkg::ptr_t    ram_raddr;
    icd_pkg::word_t   ram_rdata;

    logic             full;
    logic             empty;
    logic             valid;
    logic             finish;
    icd_pkg::status_t res_status;
    icd_pkg::word_t   res_data;
    icd_pkg::cnt_t    ins_pos;
    icd_pkg::cnt_t    sh_step;

    // physical slot of a logical position
    function automatic icd_pkg::ptr_t slot_of(icd_pkg::ptr_t base, icd_pkg::ptr_t ofs);
        icd_pkg::wide_ptr_t sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= icd_pkg::wide_ptr_t'(icd_pkg::DEPTH))
        begin
            sum = sum - icd_pkg::wide_ptr_t'(icd_pkg::DEPTH);
        end
        return icd_pkg::ptr_t'(sum);
    endfunction

    icd_ram #(
        .DEPTH_P (icd_pkg::DEPTH),
        .WIDTH_P (icd_pkg::WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full  = (occ_reg == icd_pkg::cnt_t'(icd_pkg::DEPTH));
    assign empty = (occ_reg == '0);
    assign valid = (icd_pkg::cnt_t'(idx_reg) < occ_reg);
    assign ins_pos = (icd_pkg::op_t'(op_reg) == icd_pkg::OP_INSB)
                   ? icd_pkg::cnt_t'(idx_reg)
                   : icd_pkg::cnt_t'(idx_reg) + icd_pkg::cnt_t'(1);
    assign sh_step = up_reg ? sh_i_reg - icd_pkg::cnt_t'(1)
                            : sh_i_reg + icd_pkg::cnt_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icd_pkg::S_IDLE;
            front_reg <= '0;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        sh_i_reg     <= sh_i_next;
        pos_reg      <= pos_next;
        up_reg       <= up_next;
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        front_next    = front_reg;
        occ_next      = occ_reg;
        sh_i_next     = sh_i_reg;
        pos_next      = pos_reg;
        up_next       = up_reg;
        done_next     = 1'b0;
        data_out_next = data_out_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = val_reg;
        ram_raddr     = '0;
        finish        = 1'b0;
        res_status    = icd_pkg::ST_OK;
        res_data      = '0;

        unique case (state_reg)
            icd_pkg::S_IDLE:
            begin
                // issue the read for the command as it is taken
                unique case (icd_pkg::op_t'(func)) inside
                    icd_pkg::OP_POP, icd_pkg::OP_PEEK:
                        ram_raddr = front_reg;
                    icd_pkg::OP_DEQUEUE, icd_pkg::OP_SWAPREM:
                        ram_raddr = slot_of(front_reg,
                                            icd_pkg::ptr_t'(occ_reg - icd_pkg::cnt_t'(1)));
                    default:
                        ram_raddr = slot_of(front_reg, icd_pkg::ptr_t'(index));
                endcase
                if (start)
                begin
                    op_next    = func;
                    idx_next   = index;
                    val_next   = icd_pkg::word_t'(value);
                    state_next = icd_pkg::S_EXEC;
                end
            end

            icd_pkg::S_EXEC:
            begin
                finish = 1'b1;
                unique case (icd_pkg::op_t'(op_reg)) inside
                    icd_pkg::OP_PUSH:
                    begin
                        if (full)
                        begin
                            res_status = icd_pkg::ST_FULL;
                        end
                        else
                        begin
                            front_next = (front_reg == '0)
                                       ? icd_pkg::ptr_t'(icd_pkg::DEPTH - 1)
                                       : front_reg - icd_pkg::ptr_t'(1);
                            ram_we     = 1'b1;
                            ram_waddr  = front_next;
                            occ_next   = occ_reg + icd_pkg::cnt_t'(1);
                        end
                    end
                    icd_pkg::OP_POP:
                    begin
                        if (empty)
                        begin
                            res_status = icd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_data   = ram_rdata;
                            front_next = (front_reg == icd_pkg::ptr_t'(icd_pkg::DEPTH - 1))
                                       ? '0
                                       : front_reg + icd_pkg::ptr_t'(1);
                            occ_next   = occ_reg - icd_pkg::cnt_t'(1);
                        end
                    end
                    icd_pkg::OP_ENQUEUE:
                    begin
                        if (full)
                        begin
                            res_status = icd_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_of(front_reg, icd_pkg::ptr_t'(occ_reg));
                            occ_next  = occ_reg + icd_pkg::cnt_t'(1);
                        end
                    end
                    icd_pkg::OP_DEQUEUE:
                    begin
                        if (empty)
                        begin
                            res_status = icd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_data = ram_rdata;
                            occ_next = occ_reg - icd_pkg::cnt_t'(1);
                        end
                    end
                    icd_pkg::OP_PEEK:
                    begin
                        if (empty)
                        begin
                            res_status = icd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_data = ram_rdata;
                        end
                    end
                    icd_pkg::OP_GET:
                    begin
                        if (!valid)
                        begin
                            res_status = icd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_data = ram_rdata;
                        end
                    end
                    icd_pkg::OP_SET:
                    begin
                        if (!valid)
                        begin
                            res_status = icd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_of(front_reg, icd_pkg::ptr_t'(idx_reg));
                        end
                    end
                    icd_pkg::OP_INSB, icd_pkg::OP_INSA:
                    begin
                        if (!valid)
                        begin
                            res_status = icd_pkg::ST_EMPTY;
                        end
                        else if (full)
                        begin
                            res_status = icd_pkg::ST_FULL;
                        end
                        else
                        begin
                            // move entries up from the back down to the gap
                            finish     = 1'b0;
                            up_next    = 1'b1;
                            pos_next   = ins_pos;
                            sh_i_next  = occ_reg;
                            state_next = (occ_reg == ins_pos) ? icd_pkg::S_FINAL
                                                              : icd_pkg::S_SH_RD;
                        end
                    end
                    icd_pkg::OP_REMOVE:
                    begin
                        if (!valid)
                        begin
                            res_status = icd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            // close the hole by moving later entries down
                            finish     = 1'b0;
                            up_next    = 1'b0;
                            sh_i_next  = icd_pkg::cnt_t'(idx_reg);
                            state_next = (icd_pkg::cnt_t'(idx_reg) + icd_pkg::cnt_t'(1) < occ_reg)
                                       ? icd_pkg::S_SH_RD
                                       : icd_pkg::S_FINAL;
                        end
                    end
                    icd_pkg::OP_SWAPREM:
                    begin
                        if (!valid)
                        begin
                            res_status = icd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_of(front_reg, icd_pkg::ptr_t'(idx_reg));
                            ram_wdata = ram_rdata;
                            occ_next  = occ_reg - icd_pkg::cnt_t'(1);
                        end
                    end
                    icd_pkg::OP_CLEAR:
                    begin
                        occ_next   = '0;
                        front_next = '0;
                    end
                    default:
                    begin
                        res_status = icd_pkg::ST_OK;
                    end
                endcase
            end

            icd_pkg::S_SH_RD:
            begin
                ram_raddr  = slot_of(front_reg, icd_pkg::ptr_t'(sh_step));
                state_next = icd_pkg::S_SH_WR;
            end

            icd_pkg::S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(front_reg, icd_pkg::ptr_t'(sh_i_reg));
                ram_wdata = ram_rdata;
                sh_i_next = sh_step;
                if (up_reg ? (sh_step == pos_reg)
                           : (sh_step + icd_pkg::cnt_t'(1) >= occ_reg))
                begin
                    state_next = icd_pkg::S_FINAL;
                end
                else
                begin
                    state_next = icd_pkg::S_SH_RD;
                end
            end

            icd_pkg::S_FINAL:
            begin
                finish = 1'b1;
                if (up_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(front_reg, icd_pkg::ptr_t'(pos_reg));
                    occ_next  = occ_reg + icd_pkg::cnt_t'(1);
                end
                else
                begin
                    occ_next = occ_reg - icd_pkg::cnt_t'(1);
                end
            end

            default:
            begin
                state_next = icd_pkg::S_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next     = 1'b1;
            data_out_next = icd_pkg::data_t'(res_data);
            status_next   = res_status;
            count_next    = icd_pkg::count_t'(occ_next);
            state_next    = icd_pkg::S_IDLE;
        end
    end

    assign busy     = (state_reg != icd_pkg::S_IDLE);
    assign done     = done_reg;
    assign data_out = data_out_reg;
    assign status   = status_reg;
    assign count    = count_reg;

endmodule

// ===== sv/icd_ram.sv =====
// ---------------------------------------------------------------------------
// icd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module icd_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH_P)-1:0] waddr,
    input  logic [WIDTH_P-1:0]         wdata,
    input  logic [$clog2(DEPTH_P)-1:0] raddr,
    output logic [WIDTH_P-1:0]         rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/icd_checker.sv =====
// ---------------------------------------------------------------------------
// icd_checker
// Port-level checks on the deque's command and result behavior.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module icd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] data_out,
    input logic [1:0]  status,
    input logic [4:0]  count
);

    // a result closes the command, so the block is free again
    `ICD_ASSERT_IMPL(a_done_frees, done, !busy)
    // a taken command holds off the next one
    `ICD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ICD_ASSERT_IMPL(a_count_cap, done, count <= icd_pkg::DEPTH)
    // refused operations return no data
    `ICD_ASSERT_IMPL(a_refused_zero, done && status != icd_pkg::ST_OK, data_out == '0)
    `ICD_ASSERT_IMPL(a_full_count, done && status == icd_pkg::ST_FULL, count == icd_pkg::DEPTH)

endmodule

bind indexed_circular_deque icd_checker u_icd_checker (.*);
